>>> src/tss_pkg.sv
package tss_pkg;

    // Field widths of the Q16.16 datapath.
    localparam int Q_W     = 32;
    localparam int PROD_W  = 64;
    localparam int TRUNC_W = 48;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int DIV_W   = 48;
    localparam int DCNT_W  = 6;
    localparam int ST_W    = 2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO_PIVOT = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW   = 2'd2;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [TRUNC_W-1:0] T_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [TRUNC_W-1:0] T_MIN = 48'shFFFF_8000_0000;

    // Scale a full product back to 16 fraction bits (Q32.16), truncating toward zero.
    function automatic logic signed [TRUNC_W-1:0] f_qtrunc(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] b;
        begin
            b = p + (p[PROD_W-1] ? 64'sd65535 : 64'sd0);
            return b[PROD_W-1:16];
        end
    endfunction

    // Saturated a - sat(t).
    function automatic logic signed [Q_W-1:0] f_sat_sub(input logic signed [Q_W-1:0] a,
                                                       input logic signed [TRUNC_W-1:0] t);
        logic signed [Q_W-1:0] ts;
        logic signed [Q_W:0]   d;
        begin
            if (t > T_MAX) begin
                ts = Q_MAX;
            end else if (t < T_MIN) begin
                ts = Q_MIN;
            end else begin
                ts = t[Q_W-1:0];
            end
            d = {a[Q_W-1], a} - {ts[Q_W-1], ts};
            if (d[Q_W] != d[Q_W-1]) begin
                return d[Q_W] ? Q_MIN : Q_MAX;
            end
            return d[Q_W-1:0];
        end
    endfunction

    // Magnitude of a signed Q16.16 value.
    function automatic logic [Q_W-1:0] f_mag(input logic signed [Q_W-1:0] x);
        begin
            return x[Q_W-1] ? Q_W'(-x) : Q_W'(x);
        end
    endfunction

endpackage

>>> src/tss_if.sv
interface tss_row_if;
    import tss_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [Q_W-1:0]   sub_diag;
    logic signed [Q_W-1:0]   main_diag;
    logic signed [Q_W-1:0]   super_diag;
    logic signed [Q_W-1:0]   rhs_value;
    logic                    last_row;
    modport source (output valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                    input ready);
    modport sink   (input valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                    output ready);
endinterface

interface tss_sol_if;
    import tss_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [Q_W-1:0]   solution;
    logic [IDX_W-1:0]        row_index;
    logic                    last_result;
    logic [ST_W-1:0]         status;
    modport source (output valid, solution, row_index, last_result, status, input ready);
    modport sink   (input valid, solution, row_index, last_result, status, output ready);
endinterface

>>> src/tridiagonal_system_solver.sv
// Tridiagonal solver (Thomas algorithm), Q16.16, one shared multiplier and one radix-2 divider.
// Each row takes two 48-step divisions, one for the new slope and one for the new offset.
// The block holds ready low while a row is in work, so it takes no new row until the last one is done.
// After the last row, results come out highest index first; each waits until the output takes it.
// Reset (i_rst_n low, synchronous) clears row count, status and sequencer; the row stores
// are not cleared and need no clearing pass.
module tridiagonal_system_solver #(
    parameter int MAX_ROWS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tss_row_if.sink   i_row,
    tss_sol_if.source o_sol
);
    import tss_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_FMUL   = 14'b00000000000010,
        S_FDEN   = 14'b00000000000100,
        S_FNUM   = 14'b00000000001000,
        S_DLOAD  = 14'b00000000010000,
        S_DIVC   = 14'b00000000100000,
        S_DIVD   = 14'b00000001000000,
        S_WRITE  = 14'b00000010000000,
        S_BINIT  = 14'b00000100000000,
        S_BLOAD  = 14'b00001000000000,
        S_BFIRST = 14'b00010000000000,
        S_BMUL   = 14'b00100000000000,
        S_BSUB   = 14'b01000000000000,
        S_BOUT   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]          r_row_count;
    logic [ST_W-1:0]           r_sticky;
    logic signed [Q_W-1:0]     r_sub, r_dia, r_sup, r_rhs;
    logic                      r_last;
    logic signed [Q_W-1:0]     r_prev_c, r_prev_d, r_den, r_num, r_c, r_x;
    logic signed [PROD_W-1:0]  r_prod;
    logic [IDX_W-1:0]          r_bidx;
    logic                      r_first;

    // Divider registers.
    logic [DIV_W-1:0]          r_dv_quo;
    logic [Q_W-1:0]            r_dv_rem;
    logic [Q_W-1:0]            r_dv_dvs;
    logic                      r_dv_neg;
    logic [DCNT_W-1:0]         r_dv_cnt;

    // Row stores.
    logic signed [Q_W-1:0]     slope_mem  [MAX_ROWS];
    logic signed [Q_W-1:0]     offset_mem [MAX_ROWS];
    logic signed [Q_W-1:0]     r_rd_slope, r_rd_off;

    logic in_acc, out_acc, dv_done, full;
    logic [Q_W:0]              dv_sh;
    logic                      dv_ge;
    logic signed [Q_W-1:0]     dv_result;
    logic signed [Q_W-1:0]     dv_next_n;

    assign in_acc  = i_row.valid && i_row.ready;
    assign out_acc = o_sol.valid && o_sol.ready;
    assign full    = (r_row_count >= CNT_W'(MAX_ROWS));
    assign dv_done = (r_dv_cnt == DCNT_W'(DIV_W));

    // One restoring division step.
    assign dv_sh = {r_dv_rem, r_dv_quo[DIV_W-1]};
    assign dv_ge = (dv_sh >= {1'b0, r_dv_dvs});

    // Signed, saturated quotient; a zero divisor gives zero.
    always_comb begin
        if (r_den == '0) begin
            dv_result = '0;
        end else if (r_dv_neg) begin
            if (r_dv_quo > DIV_W'(48'h0000_8000_0000)) begin
                dv_result = Q_MIN;
            end else begin
                dv_result = -$signed(r_dv_quo[Q_W-1:0]);
            end
        end else if (r_dv_quo > DIV_W'(48'h0000_7FFF_FFFF)) begin
            dv_result = Q_MAX;
        end else begin
            dv_result = $signed(r_dv_quo[Q_W-1:0]);
        end
    end

    // Numerator for the next division load.
    assign dv_next_n = r_state[5] ? r_num : r_sup;

    assign i_row.ready       = (r_state == S_IDLE);
    assign o_sol.valid       = (r_state == S_BOUT);
    assign o_sol.solution    = r_x;
    assign o_sol.row_index   = r_bidx;
    assign o_sol.last_result = (r_bidx == '0);
    assign o_sol.status      = r_sticky;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (full) begin
                        n_state = i_row.last_row ? S_BINIT : S_IDLE;
                    end else if (r_row_count == '0) begin
                        n_state = S_DLOAD;
                    end else begin
                        n_state = S_FMUL;
                    end
                end
            end
            S_FMUL:  n_state = S_FDEN;
            S_FDEN:  n_state = S_FNUM;
            S_FNUM:  n_state = S_DLOAD;
            S_DLOAD: n_state = S_DIVC;
            S_DIVC:  n_state = dv_done ? S_DIVD : S_DIVC;
            S_DIVD:  n_state = dv_done ? S_WRITE : S_DIVD;
            S_WRITE: n_state = r_last ? S_BINIT : S_IDLE;
            S_BINIT: n_state = S_BLOAD;
            S_BLOAD: n_state = r_first ? S_BFIRST : S_BMUL;
            S_BFIRST: n_state = S_BOUT;
            S_BMUL:  n_state = S_BSUB;
            S_BSUB:  n_state = S_BOUT;
            S_BOUT: begin
                if (out_acc) begin
                    n_state = (r_bidx == '0) ? S_IDLE : S_BLOAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_count <= '0;
            r_sticky    <= ST_OK;
        end else begin
            r_state <= n_state;
            if (in_acc && full && r_sticky == ST_OK) begin
                r_sticky <= ST_OVERFLOW;
            end
            if ((r_state == S_DIVC || r_state == S_DIVD) && dv_done && r_den == '0
                && r_sticky == ST_OK) begin
                r_sticky <= ST_ZERO_PIVOT;
            end
            if (r_state == S_WRITE) begin
                r_row_count <= r_row_count + 1'b1;
            end
            if (out_acc && r_bidx == '0) begin
                r_row_count <= '0;
            end
        end
    end

    // Datapath: shared multiplier, divider and back-substitution index.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_sub  <= i_row.sub_diag;
                    r_dia  <= i_row.main_diag;
                    r_sup  <= i_row.super_diag;
                    r_rhs  <= i_row.rhs_value;
                    r_last <= i_row.last_row;
                    r_den  <= i_row.main_diag;
                    r_num  <= i_row.rhs_value;
                end
            end
            S_FMUL: r_prod <= r_sub * r_prev_c;
            S_FDEN: begin
                r_den  <= f_sat_sub(r_dia, f_qtrunc(r_prod));
                r_prod <= r_sub * r_prev_d;
            end
            S_FNUM: r_num <= f_sat_sub(r_rhs, f_qtrunc(r_prod));
            S_DLOAD, S_DIVC, S_DIVD: begin
                if (r_state == S_DLOAD || dv_done) begin
                    if (r_state == S_DIVC) begin
                        r_c <= dv_result;
                    end
                    if (r_state == S_DIVD) begin
                        r_prev_d <= dv_result;
                    end
                    r_dv_quo <= {f_mag(dv_next_n), 16'h0000};
                    r_dv_rem <= '0;
                    r_dv_dvs <= f_mag(r_den);
                    r_dv_neg <= dv_next_n[Q_W-1] ^ r_den[Q_W-1];
                    r_dv_cnt <= '0;
                end else begin
                    r_dv_rem <= dv_ge ? Q_W'(dv_sh - {1'b0, r_dv_dvs}) : dv_sh[Q_W-1:0];
                    r_dv_quo <= {r_dv_quo[DIV_W-2:0], dv_ge};
                    r_dv_cnt <= r_dv_cnt + 1'b1;
                end
            end
            S_WRITE: r_prev_c <= r_c;
            S_BINIT: begin
                r_bidx  <= IDX_W'(r_row_count - 1'b1);
                r_first <= 1'b1;
            end
            S_BFIRST: r_x <= r_rd_off;
            S_BMUL: r_prod <= r_rd_slope * r_x;
            S_BSUB: r_x <= f_sat_sub(r_rd_off, f_qtrunc(r_prod));
            S_BOUT: begin
                if (out_acc && r_bidx != '0) begin
                    r_bidx  <= r_bidx - 1'b1;
                    r_first <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Row stores: written at the end of each row, read during back substitution.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            slope_mem[r_row_count[IDX_W-1:0]]  <= r_last ? '0 : r_c;
            offset_mem[r_row_count[IDX_W-1:0]] <= r_prev_d;
        end
        r_rd_slope <= slope_mem[r_bidx];
        r_rd_off   <= offset_mem[r_bidx];
    end

    // The row count never passes the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_count <= CNT_W'(MAX_ROWS))
        else $error("row count beyond store depth");

    // Once set, the status code holds until reset.
    a_sticky_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sticky != ST_OK |=> r_sticky == $past(r_sticky))
        else $error("sticky status changed");

    // Taking the final result ends the system.
    a_end_system: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_bidx == '0 |=> r_row_count == '0 && r_state == S_IDLE)
        else $error("system not closed after final result");

    // No row is taken while results are pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sol.valid |-> !i_row.ready)
        else $error("row request accepted during output");

endmodule
